// ===== rtl/pid_controller_antiwindup_defines.svh =====
// assertion macros used by the top-level rtl
`ifndef PID_CONTROLLER_ANTIWINDUP_DEFINES_SVH
`define PID_CONTROLLER_ANTIWINDUP_DEFINES_SVH
`ifndef SYNTHESIS
`define PCA_ASSERT(lbl, prop) lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
  prop) else $error("pca assertion failed");
`define PCA_ASSERT_RST(lbl, prop) lbl: assert property (@(posedge clk_i) \
  prop) else $error("pca reset assertion failed");
`else
`define PCA_ASSERT(lbl, prop)
`define PCA_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== rtl/pca_pkg.sv =====
`timescale 1ns / 1ps
package pca_pkg;
  localparam int VW       = 32;
  localparam int FB       = 16;
  localparam int TW       = 24;
  localparam int TF       = 16;
  localparam int LW       = 31;
  localparam int EW       = VW + 1;
  localparam int HALF_W   = 16;
  localparam int PART_W   = EW + HALF_W + 1;
  localparam int PROD_W   = 2 * EW;
  localparam int TERM_W   = PROD_W - FB;
  localparam int SUM_W    = 56;
  localparam int NUM_W    = EW + FB;
  localparam int CNT_W    = 6;
  localparam int IDX_W    = 3;
  localparam int IN_TDATA_W = 88;

  localparam logic [IDX_W-1:0] REG_GP  = 3'd0;
  localparam logic [IDX_W-1:0] REG_GI  = 3'd1;
  localparam logic [IDX_W-1:0] REG_GD  = 3'd2;
  localparam logic [IDX_W-1:0] REG_LO  = 3'd3;
  localparam logic [IDX_W-1:0] REG_HI  = 3'd4;
  localparam logic [IDX_W-1:0] REG_LIM = 3'd5;

  localparam logic [2:0] OP_P  = 3'd0;
  localparam logic [2:0] OP_D  = 3'd1;
  localparam logic [2:0] OP_I0 = 3'd2;
  localparam logic [2:0] OP_T  = 3'd3;
  localparam logic [2:0] OP_I1 = 3'd4;

  typedef struct packed {
    logic signed [VW-1:0] gp;
    logic signed [VW-1:0] gi;
    logic signed [VW-1:0] gd;
    logic signed [VW-1:0] lo;
    logic signed [VW-1:0] hi;
    logic [LW-1:0]        lim;
  } cfg_t;

  typedef struct packed {
    logic       clear;
    logic       load;
    logic       div_step;
    logic       deriv_fin;
    logic       mul_lo;
    logic       mul_hi;
    logic       mul_acc;
    logic       out_load;
    logic [2:0] op;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;
endpackage

// ===== rtl/pca_cfg.sv =====
`timescale 1ns / 1ps
module pca_cfg import pca_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [IDX_W-1:0] index_i,
  input  logic [VW-1:0]    data_i,
  output cfg_t             cfg_o
);
  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (index_i)
        REG_GP:  cfg_d.gp = data_i;
        REG_GI:  cfg_d.gi = data_i;
        REG_GD:  cfg_d.gd = data_i;
        REG_LO:  cfg_d.lo = data_i;
        REG_HI:  cfg_d.hi = data_i;
        REG_LIM: cfg_d.lim = data_i[LW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gp  <= '0;
      cfg_q.gi  <= '0;
      cfg_q.gd  <= '0;
      cfg_q.lo  <= -(VW'(1) << FB);
      cfg_q.hi  <= VW'(1) << FB;
      cfg_q.lim <= LW'(1) << FB;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;
endmodule

// ===== rtl/pca_ctrl.sv =====
`timescale 1ns / 1ps
module pca_ctrl import pca_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_clear_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_DFIN = 3'd2;
  localparam logic [2:0] ST_MLO  = 3'd3;
  localparam logic [2:0] ST_MHI  = 3'd4;
  localparam logic [2:0] ST_MACC = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(NUM_W - 1);

  logic [2:0]       state_q, state_d;
  logic [2:0]       op_q, op_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.op = op_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_clear_i) begin
            cmd_o.clear = 1'b1;
          end else begin
            cmd_o.load = 1'b1;
            cnt_d      = '0;
            state_d    = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == LAST_BIT) state_d = ST_DFIN;
      end
      ST_DFIN: begin
        cmd_o.deriv_fin = 1'b1;
        op_d            = OP_P;
        state_d         = ST_MLO;
      end
      ST_MLO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = ST_MHI;
      end
      ST_MHI: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = ST_MACC;
      end
      ST_MACC: begin
        cmd_o.mul_acc = 1'b1;
        state_d       = ST_MLO;
        unique case (op_q)
          OP_P:  op_d = OP_D;
          OP_D:  op_d = OP_I0;
          OP_I0: op_d = OP_T;
          OP_T:  op_d = OP_I1;
          default: state_d = ST_FIN;
        endcase
      end
      ST_FIN: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_P;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      cnt_q   <= cnt_d;
    end
  end
endmodule

// ===== rtl/pca_dp.sv =====
`timescale 1ns / 1ps
module pca_dp import pca_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  cmd_t                 cmd_i,
  output status_t              status_o,
  input  logic signed [VW-1:0] target_i,
  input  logic signed [VW-1:0] sample_i,
  input  logic [TW-1:0]        step_time_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [VW-1:0]        drive_o
);
  logic signed [VW-1:0]     acc_q, last_q, deriv_q;
  logic signed [EW-1:0]     err_q;
  logic [TW-1:0]            dt_q;
  logic [NUM_W-1:0]         num_q, quo_q;
  logic [TW-1:0]            rem_q;
  logic                     neg_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [SUM_W-1:0]  pd_q, iterm_q;
  logic                     valid_q;
  logic [VW-1:0]            drive_q;

  logic signed [EW-1:0]     diff, mag;
  logic [TW:0]              rem2;
  logic                     ge;
  logic signed [VW-1:0]     deriv_val;
  logic signed [EW-1:0]     op_a, op_b;
  logic signed [HALF_W:0]   b_half;
  logic signed [PART_W-1:0] part;
  logic signed [TERM_W-1:0] term;
  logic signed [SUM_W-1:0]  total, acc_sum, lim_pos, lim_neg, hi_s, lo_s, res;
  logic                     pin_hi, pin_lo;

  assign diff = EW'(last_q) - EW'(sample_i);
  assign mag  = diff[EW-1] ? -diff : diff;

  assign rem2 = {rem_q, num_q[NUM_W-1]};
  assign ge   = rem2 >= {1'b0, dt_q};

  always_comb begin
    if (dt_q == '0) begin
      deriv_val = '0;
    end else if (!neg_q) begin
      deriv_val = (quo_q[NUM_W-1:VW-1] != '0) ? {1'b0, {(VW-1){1'b1}}}
                                               : $signed(quo_q[VW-1:0]);
    end else if ((quo_q[NUM_W-1:VW] != '0) || (quo_q[VW-1] && (quo_q[VW-2:0] != '0))) begin
      deriv_val = {1'b1, {(VW-1){1'b0}}};
    end else begin
      deriv_val = -$signed(quo_q[VW-1:0]);
    end
  end

  always_comb begin
    op_a = err_q;
    op_b = EW'(cfg_i.gp);
    case (cmd_i.op)
      OP_D: begin
        op_a = EW'(deriv_q);
        op_b = EW'(cfg_i.gd);
      end
      OP_I0, OP_I1: begin
        op_a = EW'(acc_q);
        op_b = EW'(cfg_i.gi);
      end
      OP_T: begin
        op_a = err_q;
        op_b = $signed({1'b0, {(EW-TW-1){1'b0}}, dt_q});
      end
      default: ;
    endcase
  end

  // two half products of the shared multiplier
  assign b_half = cmd_i.mul_hi ? op_b[EW-1:HALF_W] : $signed({1'b0, op_b[HALF_W-1:0]});
  assign part   = op_a * b_half;
  assign term   = prod_q[PROD_W-1:FB];

  assign total   = pd_q + iterm_q;
  assign hi_s    = SUM_W'(cfg_i.hi);
  assign lo_s    = SUM_W'(cfg_i.lo);
  assign pin_hi  = (total >= hi_s) && !err_q[EW-1] && (err_q != '0);
  assign pin_lo  = (total <= lo_s) && err_q[EW-1];
  assign acc_sum = SUM_W'(acc_q) + SUM_W'(term);
  assign lim_pos = $signed({{(SUM_W-LW){1'b0}}, cfg_i.lim});
  assign lim_neg = -lim_pos;

  always_comb begin
    res = total;
    if (res > hi_s) res = hi_s;
    if (res < lo_s) res = lo_s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      last_q <= '0;
    end else if (cmd_i.clear) begin
      acc_q  <= '0;
      last_q <= '0;
    end else begin
      if (cmd_i.load) last_q <= sample_i;
      if (cmd_i.mul_acc && (cmd_i.op == OP_T) && !pin_hi && !pin_lo) begin
        if (acc_sum > lim_pos) acc_q <= lim_pos[VW-1:0];
        else if (acc_sum < lim_neg) acc_q <= lim_neg[VW-1:0];
        else acc_q <= acc_sum[VW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      err_q <= EW'(target_i) - EW'(sample_i);
      dt_q  <= step_time_i;
      num_q <= {mag, {FB{1'b0}}};
      neg_q <= diff[EW-1];
      rem_q <= '0;
      quo_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? TW'(rem2 - {1'b0, dt_q}) : rem2[TW-1:0];
      num_q <= {num_q[NUM_W-2:0], 1'b0};
      quo_q <= {quo_q[NUM_W-2:0], ge};
    end
    if (cmd_i.deriv_fin) begin
      deriv_q <= deriv_val;
      pd_q    <= '0;
    end
    if (cmd_i.mul_lo) prod_q <= PROD_W'(part);
    if (cmd_i.mul_hi) prod_q <= prod_q + (PROD_W'(part) <<< HALF_W);
    if (cmd_i.mul_acc) begin
      case (cmd_i.op)
        OP_P, OP_D:   pd_q    <= pd_q + SUM_W'(term);
        OP_I0, OP_I1: iterm_q <= SUM_W'(term);
        default: ;
      endcase
    end
    if (cmd_i.out_load) drive_q <= res[VW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (cmd_i.out_load) valid_q <= 1'b1;
    else if (out_ready_i) valid_q <= 1'b0;
  end

  assign status_o.out_free = !valid_q || out_ready_i;
  assign out_valid_o       = valid_q;
  assign drive_o           = drive_q;
endmodule

// ===== rtl/pid_controller_antiwindup.sv =====
// sequence: a step item is loaded, the bit-serial derivative divider forms a 49-bit
// quotient, the derivative is saturated, five products run on the shared 33x17
// multiplier, and the clamped result is loaded once the output is free; s_tready is
// high only in idle, so a new item waits for that load; a clear item leaves it idle
// reset: asynchronous active low, clears integral, last sample, gains to zero,
// bounds to -1.0 / +1.0 and the integral limit to 1.0
`timescale 1ns / 1ps
`include "pid_controller_antiwindup_defines.svh"
module pid_controller_antiwindup import pca_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_TDATA_W-1:0] s_tdata,  // target, sample, step_time
  input  logic                  s_tuser,  // clear
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [VW-1:0]         m_tdata,  // drive
  input  logic                  cfg_we_i,
  input  logic [IDX_W-1:0]      cfg_index_i,
  input  logic [VW-1:0]         cfg_data_i
);
  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;
  logic    drive_in_bounds;

  pca_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  pca_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_tvalid),
    .in_clear_i (s_tuser),
    .in_ready_o (s_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pca_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .status_o    (status),
    .target_i    (s_tdata[VW-1:0]),
    .sample_i    (s_tdata[2*VW-1:VW]),
    .step_time_i (s_tdata[2*VW+TW-1:2*VW]),
    .out_valid_o (m_tvalid),
    .out_ready_i (m_tready),
    .drive_o     (m_tdata)
  );

  assign drive_in_bounds = ($signed(m_tdata) <= cfg.hi) && ($signed(m_tdata) >= cfg.lo);

  `PCA_ASSERT(a_busy_after_step, s_tvalid && s_tready && !s_tuser |=> !s_tready)
  `PCA_ASSERT(a_drive_in_bounds, m_tvalid && (cfg.lo <= cfg.hi) |-> drive_in_bounds)
  `PCA_ASSERT_RST(a_no_result_in_reset, !rst_ni |=> !m_tvalid || $past(rst_ni))
endmodule
